### rtl/catmull_rom_spline_evaluator_unit_macros.svh
// Assertion macros for the spline evaluator.
// Used by the top level only; assumes aclk and aresetn in scope.
`ifndef CATMULL_ROM_SPLINE_EVALUATOR_UNIT_MACROS_SVH
`define CATMULL_ROM_SPLINE_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define CRSE_ASSERT(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("crse assertion failed");
`define CRSE_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("crse assertion failed");
`else
`define CRSE_ASSERT(label, expr)
`define CRSE_ASSERT_NEXT(label, pre, post)
`endif
`endif

### rtl/crse_pkg.sv
// Shared types and constants for the spline evaluator.
// No dependencies.
`default_nettype none
package crse_pkg;
    localparam int MAX_POINTS_DEF = 256;
    localparam int CMP_W  = 13;
    localparam int PT_W   = 32;
    localparam int U_W    = 17;
    localparam int SEG_W  = 8;
    localparam int EXT_W  = 34;
    localparam int COEF_W = 40;
    localparam int ACC_W  = 44;
    localparam logic [U_W-1:0] U_ONE = 17'd65536;

    typedef enum logic [2:0] {
        ST_EVAL    = 3'd0,
        ST_STORED  = 3'd1,
        ST_FULL    = 3'd2,
        ST_SEGMENT = 3'd3,
        ST_URANGE  = 3'd4
    } status_t;

    typedef logic [2:0][PT_W-1:0] point_t;
    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic           valid;
        status_t        status;
        logic [U_W-1:0] u;
    } ctl_t;
endpackage
`default_nettype wire

### rtl/catmull_rom_spline_evaluator_unit.sv
// Top level of the uniform Catmull-Rom 3D spline evaluator.
// Depends on crse_pkg, crse_point_store, crse_coeff, crse_horner_stage, macros header.
//
//  channel   | ports                                              | direction
//  ----------+----------------------------------------------------+----------
//  request   | s_valid s_ready s_req_type s_point_* s_param_u ... | in
//  result    | m_valid m_ready m_curve_x/y/z m_status             | out
//
// One transaction accepted per cycle while the pipeline can advance; each yields
// exactly one result transaction after table read, extrapolation, coefficients,
// three Horner multiply steps and round/saturate into the output register.
// All stages advance together whenever the output register is empty or taken,
// so a stall freezes the whole pipeline and nothing is lost or repeated.
// Reset (aresetn low, synchronous) empties the table and clears all valid bits;
// table contents need no clearing; unstored data that is read never reaches a result.
`default_nettype none
`include "catmull_rom_spline_evaluator_unit_macros.svh"
module catmull_rom_spline_evaluator_unit #(
    parameter int MAX_POINTS = crse_pkg::MAX_POINTS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_req_type,
    input  wire logic signed [crse_pkg::PT_W-1:0] s_point_x,
    input  wire logic signed [crse_pkg::PT_W-1:0] s_point_y,
    input  wire logic signed [crse_pkg::PT_W-1:0] s_point_z,
    input  wire logic [crse_pkg::U_W-1:0]      s_param_u,
    input  wire logic [crse_pkg::SEG_W-1:0]    s_segment_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [crse_pkg::PT_W-1:0]   m_curve_x,
    output logic signed [crse_pkg::PT_W-1:0]   m_curve_y,
    output logic signed [crse_pkg::PT_W-1:0]   m_curve_z,
    output logic [2:0]                         m_status
);
    import crse_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // pipeline advance: output slot free or being taken
    logic adv, accept;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    // ---- request decode and table write (accept edge) ----
    logic [CW-1:0]    count_reg, count_next;
    logic [CMP_W-1:0] seg_w, cnt_w;
    logic             full, append_ok;
    ctl_t             ctl0;
    logic             first0, last0;

    assign seg_w     = CMP_W'(s_segment_index);
    assign cnt_w     = CMP_W'(count_reg);
    assign full      = count_reg == CW'(MAX_POINTS);
    assign append_ok = accept && !s_req_type && !full;
    assign first0    = s_segment_index == '0;
    assign last0     = seg_w + CMP_W'(2) >= cnt_w;

    always_comb begin
        ctl0.valid = s_valid;
        ctl0.u     = s_param_u;
        if (!s_req_type) begin
            ctl0.status = full ? ST_FULL : ST_STORED;
        end else if (seg_w + CMP_W'(1) >= cnt_w) begin
            ctl0.status = ST_SEGMENT;
        end else if (s_param_u > U_ONE) begin
            ctl0.status = ST_URANGE;
        end else begin
            ctl0.status = ST_EVAL;
        end
        count_next = count_reg + CW'(append_ok);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // four neighbor reads: points seg-1, seg, seg+1, seg+2
    logic [AW-1:0] rd_addr [4];
    point_t        rd_data [4];
    point_t        wr_data;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            rd_addr[k] = AW'(seg_w + CMP_W'(k) - CMP_W'(1));
        end
    end
    assign wr_data = {s_point_z, s_point_y, s_point_x};

    crse_point_store #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (append_ok),
        .wr_addr (AW'(count_reg)),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // stage 1 sideband, aligned with the registered table reads
    ctl_t ctl1_reg;
    logic first1_reg, last1_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg.valid <= 1'b0;
        end else if (adv) begin
            ctl1_reg <= ctl0;
        end
        if (adv) begin
            first1_reg <= first0;
            last1_reg  <= last0;
        end
    end

    // ---- coefficients (stages 2 and 3) ----
    ctl_t  ctl3;
    coef_t coef [3][4];
    crse_coeff u_coeff (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .ctl_in  (ctl1_reg),
        .p_in    (rd_data),
        .first   (first1_reg),
        .last    (last1_reg),
        .ctl_out (ctl3),
        .c_out   (coef)
    );

    // ---- Horner evaluation (stages 4 to 6) ----
    acc_t  acc3 [3], acc4 [3], acc5 [3], acc6 [3];
    coef_t ck2 [3], c1_d_reg [3], c0_d_reg [3], c0_dd_reg [3];
    ctl_t  ctl4, ctl5, ctl6;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            acc3[a] = ACC_W'(coef[a][3]);
            ck2[a]  = coef[a][2];
        end
    end

    // later coefficients ride along with their Horner step
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int a = 0; a < 3; a++) begin
                c1_d_reg[a]  <= coef[a][1];
                c0_d_reg[a]  <= coef[a][0];
                c0_dd_reg[a] <= c0_d_reg[a];
            end
        end
    end

    crse_horner_stage u_h2 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .ctl_in(ctl3), .acc_in(acc3), .ck(ck2), .ctl_out(ctl4), .acc_out(acc4)
    );
    crse_horner_stage u_h1 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .ctl_in(ctl4), .acc_in(acc4), .ck(c1_d_reg), .ctl_out(ctl5), .acc_out(acc5)
    );
    crse_horner_stage u_h0 (
        .aclk(aclk), .aresetn(aresetn), .en(adv),
        .ctl_in(ctl5), .acc_in(acc5), .ck(c0_dd_reg), .ctl_out(ctl6), .acc_out(acc6)
    );

    // ---- round half up, saturate, zero on error (output register) ----
    logic [2:0][PT_W-1:0] res_next, res_reg;
    acc_t                 rnd [3];
    logic                 out_valid_reg;
    status_t              out_status_reg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rnd[a] = (acc6[a] + ACC_W'(1)) >>> 1;
            if (ctl6.status != ST_EVAL) begin
                res_next[a] = '0;
            end else if (rnd[a] > ACC_W'(32'sh7fffffff)) begin
                res_next[a] = 32'h7fffffff;
            end else if (rnd[a] < ACC_W'(-33'sh80000000)) begin
                res_next[a] = 32'h80000000;
            end else begin
                res_next[a] = PT_W'(rnd[a]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= ctl6.valid;
        end
        if (adv) begin
            res_reg        <= res_next;
            out_status_reg <= ctl6.status;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_curve_x = $signed(res_reg[0]);
    assign m_curve_y = $signed(res_reg[1]);
    assign m_curve_z = $signed(res_reg[2]);
    assign m_status  = out_status_reg;

    // ---- assertions ----
    `CRSE_ASSERT(a_count_bound, count_reg <= CW'(MAX_POINTS))
    `CRSE_ASSERT(a_err_zero, !m_valid || out_status_reg == ST_EVAL || res_reg == '0)
    `CRSE_ASSERT_NEXT(a_count_inc, append_ok, count_reg == $past(count_reg) + CW'(1))
    `CRSE_ASSERT_NEXT(a_stall_hold, m_valid && !m_ready, $stable(ctl6) && $stable(ctl3))
endmodule
`default_nettype wire

### rtl/crse_point_store.sv
// Control point table: four copies, one per neighbor read, registered reads.
// Depends on crse_pkg.
`default_nettype none
module crse_point_store #(
    parameter int MAX_POINTS = crse_pkg::MAX_POINTS_DEF,
    parameter int AW = $clog2(MAX_POINTS)
) (
    input  wire logic            aclk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire crse_pkg::point_t wr_data,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr [4],
    output crse_pkg::point_t     rd_data [4]
);
    import crse_pkg::*;

    for (genvar b = 0; b < 4; b++) begin : g_copy
        point_t mem [MAX_POINTS];
        point_t rd_reg;
        always_ff @(posedge aclk) begin
            if (wr_en) begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
                rd_reg <= mem[rd_addr[b]];
            end
        end
        assign rd_data[b] = rd_reg;
    end
endmodule
`default_nettype wire

### rtl/crse_coeff.sv
// Two stages: end point extrapolation, then doubled Catmull-Rom coefficients.
// Depends on crse_pkg.
`default_nettype none
module crse_coeff (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire crse_pkg::ctl_t   ctl_in,
    input  wire crse_pkg::point_t p_in [4],
    input  wire logic        first,
    input  wire logic        last,
    output crse_pkg::ctl_t   ctl_out,
    output crse_pkg::coef_t  c_out [3][4]
);
    import crse_pkg::*;

    ctl_t ctl_a_reg, ctl_b_reg;
    logic signed [EXT_W-1:0] e_reg [3][4];
    logic signed [EXT_W-1:0] e_next [3][4];
    coef_t c_reg [3][4];
    coef_t c_next [3][4];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 4; k++) begin
                e_next[a][k] = EXT_W'($signed(p_in[k][a]));
            end
            // missing outer points: 2*p1-p2 before, 2*p2-p1 after
            if (first) begin
                e_next[a][0] = 2 * e_next[a][1] - e_next[a][2];
            end
            if (last) begin
                e_next[a][3] = 2 * e_next[a][2] - e_next[a][1];
            end
        end
        for (int a = 0; a < 3; a++) begin
            c_next[a][0] = 2 * COEF_W'(e_reg[a][1]);
            c_next[a][1] = COEF_W'(e_reg[a][2]) - COEF_W'(e_reg[a][0]);
            c_next[a][2] = 2 * COEF_W'(e_reg[a][0]) - 5 * COEF_W'(e_reg[a][1])
                         + 4 * COEF_W'(e_reg[a][2]) - COEF_W'(e_reg[a][3]);
            c_next[a][3] = 3 * COEF_W'(e_reg[a][1]) - COEF_W'(e_reg[a][0])
                         - 3 * COEF_W'(e_reg[a][2]) + COEF_W'(e_reg[a][3]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg.valid <= 1'b0;
            ctl_b_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
        if (en) begin
            e_reg <= e_next;
            c_reg <= c_next;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign c_out   = c_reg;
endmodule
`default_nettype wire

### rtl/crse_horner_stage.sv
// One Horner step for three axes: acc = ck + floor(acc*u / 2^16).
// Depends on crse_pkg.
`default_nettype none
module crse_horner_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire crse_pkg::ctl_t  ctl_in,
    input  wire crse_pkg::acc_t  acc_in [3],
    input  wire crse_pkg::coef_t ck [3],
    output crse_pkg::ctl_t  ctl_out,
    output crse_pkg::acc_t  acc_out [3]
);
    import crse_pkg::*;

    ctl_t ctl_reg;
    acc_t acc_reg [3];
    acc_t acc_next [3];
    logic signed [ACC_W+U_W:0] prod [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod[a] = acc_in[a] * $signed({1'b0, ctl_in.u});
            acc_next[a] = ACC_W'(prod[a] >>> 16) + ACC_W'(ck[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
        if (en) begin
            acc_reg <= acc_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign acc_out = acc_reg;
endmodule
`default_nettype wire

### tb/catmull_rom_spline_evaluator_unit_tb.sv
// Self-checking testbench for the Catmull-Rom 3D spline evaluator.
// Depends on crse_pkg and the catmull_rom_spline_evaluator_unit RTL.
`default_nettype none
module catmull_rom_spline_evaluator_unit_tb;
    import crse_pkg::*;

    localparam int NPTS = 256;

    // Expected result of one transaction.
    typedef struct {
        logic signed [31:0] x, y, z;
        status_t            st;
    } curve_result_t;

    // Scoreboard: holds a private copy of the point table and predicts each result.
    class spline_scoreboard;
        longint        pts[NPTS][3];
        int            npts;
        curve_result_t pending[$];
        int            mismatches;

        function void clear();
            npts = 0;
            pending.delete();
            mismatches = 0;
        endfunction

        // floor(v / 2^s); >>> on a signed longint already floors
        function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        function logic signed [31:0] eval_axis(longint c[4], longint u);
            longint acc;
            acc = c[3];
            for (int k = 2; k >= 0; k--) acc = c[k] + fshift(acc * u, 16);
            acc = fshift(acc + 1, 1);
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            return acc[31:0];
        endfunction

        // Note an accepted request and queue its expected result.
        function void note_request(bit req, logic signed [31:0] px, py, pz,
                                   logic [16:0] u, logic [7:0] seg);
            curve_result_t r;
            longint p0, p1, p2, p3;
            longint c[4];
            logic signed [31:0] ax[3];
            r.x = 0; r.y = 0; r.z = 0;
            if (!req) begin
                if (npts >= NPTS) r.st = ST_FULL;
                else begin
                    pts[npts][0] = px; pts[npts][1] = py; pts[npts][2] = pz;
                    npts++;
                    r.st = ST_STORED;
                end
            end else if (int'(seg) + 1 >= npts) begin
                r.st = ST_SEGMENT;
            end else if (u > U_ONE) begin
                r.st = ST_URANGE;
            end else begin
                for (int a = 0; a < 3; a++) begin
                    p1 = pts[seg][a];
                    p2 = pts[seg + 1][a];
                    p0 = (seg >= 1) ? pts[seg - 1][a] : 2 * p1 - p2;
                    p3 = (int'(seg) + 2 < npts) ? pts[seg + 2][a] : 2 * p2 - p1;
                    c[0] = 2 * p1;
                    c[1] = p2 - p0;
                    c[2] = 2 * p0 - 5 * p1 + 4 * p2 - p3;
                    c[3] = -p0 + 3 * p1 - 3 * p2 + p3;
                    ax[a] = eval_axis(c, longint'(u));
                end
                r.x = ax[0]; r.y = ax[1]; r.z = ax[2];
                r.st = ST_EVAL;
            end
            pending.insert(pending.size(), r);
        endfunction

        // Compare one result transaction with the oldest prediction.
        function void check_result(logic signed [31:0] x, y, z, logic [2:0] st);
            curve_result_t e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result st=%0d", st);
                return;
            end
            e = pending.pop_front();
            if (x !== e.x || y !== e.y || z !== e.z || st !== e.st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %h %h %h st=%0d, got %h %h %h st=%0d",
                             e.x, e.y, e.z, e.st, x, y, z, st);
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_req_type = 0;
    logic signed [31:0] s_point_x = 0, s_point_y = 0, s_point_z = 0;
    logic [16:0]        s_param_u = 0;
    logic [7:0]         s_segment_index = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_curve_x, m_curve_y, m_curve_z;
    logic [2:0]         m_status;

    catmull_rom_spline_evaluator_unit dut (.*);

    always #5 aclk = ~aclk;

    spline_scoreboard sb = new();
    int src_idle_pct = 0;   // chance, in percent, that the sender idles a cycle
    int snk_stall_pct = 0;  // chance that the receiver stalls a cycle
    longint cycle_count = 0;

    // Receiver: randomized ready, check on each result transaction.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_curve_x, m_curve_y, m_curve_z, m_status);
            m_ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        if (cycle_count > 600000) begin
            $display("catmull_rom_spline_evaluator_unit_tb: errors");
            $finish;
        end
    end

    // Drive one request transaction and wait for its acceptance.
    // Valid stays high afterwards until an idle cycle or the end of stimulus.
    task automatic send_request(bit req, logic signed [31:0] px, py, pz,
                                logic [16:0] u, logic [7:0] seg);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_req_type <= req;
        s_point_x <= px; s_point_y <= py; s_point_z <= pz;
        s_param_u <= u; s_segment_index <= seg;
        do @(posedge aclk); while (!(s_ready && s_valid));
        sb.note_request(req, px, py, pz, u, seg);
    endtask

    task automatic append_point(logic signed [31:0] px, py, pz);
        send_request(0, px, py, pz, 17'($urandom), 8'($urandom));
    endtask

    task automatic evaluate(logic [16:0] u, logic [7:0] seg);
        send_request(1, $urandom, $urandom, $urandom, u, seg);
    endtask

    // Random u: mostly legal, sometimes the edges or above one.
    function automatic logic [16:0] rand_u();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return U_ONE;
            2: return 17'($urandom_range(131071, 65537));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    // Random point coordinate: usually modest, sometimes full range.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(7))
            0: return 32'($urandom);
            1: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    // One random phase: a fresh table is not possible without reset, so the
    // table grows across phases and finally fills up.
    task automatic random_phase(int n, int idle, int stall);
        int seg_hi;
        src_idle_pct = idle;
        snk_stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 12) append_point(rand_coord(), rand_coord(), rand_coord());
            else begin
                seg_hi = (sb.npts > 1) ? sb.npts - 1 : 0;
                if ($urandom_range(19) == 0) evaluate(rand_u(), 8'($urandom));
                else evaluate(rand_u(), 8'($urandom_range(seg_hi)));
            end
        end
    endtask

    initial begin
        sb.clear();
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: empty-table evaluate, one point, then the extremes.
        evaluate(17'd0, 8'd0);
        append_point(32'h7fffffff, 32'h80000000, 32'h0);
        evaluate(17'd100, 8'd0);
        append_point(32'h80000000, 32'h7fffffff, 32'hffffffff);
        evaluate(17'd0, 8'd0);          // both neighbors extrapolated
        evaluate(U_ONE, 8'd0);
        evaluate(17'd32768, 8'd0);      // midpoint between the two points
        evaluate(17'd65537, 8'd0);      // u above one
        evaluate(17'h1ffff, 8'd255);    // segment check wins over u check
        append_point(32'h00010000, 32'h00020000, 32'hfffe0000);
        append_point(32'h00030000, 32'h0, 32'h00050000);
        evaluate(17'd12345, 8'd0);
        evaluate(17'd12345, 8'd1);      // interior segment
        evaluate(17'd12345, 8'd1);      // same request repeated
        evaluate(17'd40000, 8'd2);      // last segment
        evaluate(17'd1, 8'd3);          // out of range
        evaluate(17'h1ffff, 8'd2);

        random_phase(450, 0, 0);
        random_phase(450, 82, 0);
        random_phase(450, 0, 82);
        random_phase(300, 23, 23);

        // Fill the table, then hit the full case and the top segments.
        src_idle_pct = 10; snk_stall_pct = 10;
        while (sb.npts < NPTS) append_point(rand_coord(), rand_coord(), rand_coord());
        append_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        evaluate(rand_u(), 8'd254);
        evaluate(17'd0, 8'd255);
        random_phase(150, 0, 0);
        s_valid <= 0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0) $display("catmull_rom_spline_evaluator_unit_tb: clean");
        else $display("catmull_rom_spline_evaluator_unit_tb: errors");
        $finish;
    end
endmodule
`default_nettype wire
